// ===== rtl/sorted_priority_queue_top_macros.svh =====
// Assertion macros shared by the checker of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int ENTRY_COUNT_W = 7;
  localparam int CMD_FIFO_DEPTH = 2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_REFUSE_FULL,
    OP_REFUSE_EMPTY
  } op_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_REMOVE
  } back_state_t;

  typedef struct packed {
    logic                      action;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    status_t                   status;
    logic                      is_empty;
    logic                      is_full;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic signed [VALUE_W-1:0] value;
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/spq_ram.sv =====
`default_nettype none
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/spq_front.sv =====
`default_nettype none
module spq_front #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  wire spq_pkg::in_word_t cmd,
  output logic                   op_push,
  input  wire logic              op_room,
  output spq_pkg::op_t           op
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Occupancy as it will be once every queued operation has run.
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;

  assign cmd_stall = !op_room;
  assign op_push   = cmd_valid && op_room;

  always_comb begin
    fill_next = fill;
    op.value  = cmd.value;
    if (cmd.action == ACT_INSERT) begin
      if (fill == CNT_W'(QUEUE_DEPTH)) begin
        op.kind = OP_REFUSE_FULL;
      end else begin
        op.kind   = OP_INSERT;
        fill_next = fill + CNT_W'(1);
      end
    end else begin
      if (fill == '0) begin
        op.kind = OP_REFUSE_EMPTY;
      end else begin
        op.kind   = OP_REMOVE;
        fill_next = fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (op_push) begin
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spq_op_fifo.sv =====
`default_nettype none
module spq_op_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire spq_pkg::op_t push_op,
  output logic              room,
  input  wire logic         pop,
  output logic              avail,
  output spq_pkg::op_t      head_op
);
  import spq_pkg::*;

  localparam int PTR_W  = $clog2(CMD_FIFO_DEPTH);
  localparam int FILL_W = $clog2(CMD_FIFO_DEPTH + 1);

  op_t               slots [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign room    = fill != FILL_W'(CMD_FIFO_DEPTH);
  assign avail   = fill != '0;
  assign head_op = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= step(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= step(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spq_back.sv =====
`default_nettype none
module spq_back #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          op_avail,
  input  wire spq_pkg::op_t  head_op,
  output logic               op_pop,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output spq_pkg::out_word_t rsp
);
  import spq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  back_state_t       state;
  back_state_t       state_next;
  op_t               cur;
  op_t               cur_next;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  head_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [IDX_W-1:0]  rd_ptr;
  logic [IDX_W-1:0]  rd_ptr_next;
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  wr_ptr_next;
  logic [CNT_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  scan_idx_next;
  out_word_t         rsp_next;
  logic              rsp_load;
  logic [CNT_W-1:0]  res_count;
  logic              start;
  logic              shift_more;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [VALUE_W-1:0] wdata;
  logic [IDX_W-1:0]   raddr;
  logic [VALUE_W-1:0] rdata;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(QUEUE_DEPTH - 1) : p - IDX_W'(1);
  endfunction

  spq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A new operation is taken only when the result register is empty.
  assign start = (state == BK_IDLE) && op_avail && !rsp_valid;
  // The entry just read is a live entry and larger than the value being placed, so it moves up.
  assign shift_more = (scan_idx < count) && ($signed(rdata) > $signed(cur.value));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (start && head_op.kind == OP_INSERT) begin
          state_next = BK_SCAN;
        end else if (start && head_op.kind == OP_REMOVE) begin
          state_next = BK_REMOVE;
        end
      end
      BK_SCAN: begin
        if (!shift_more) begin
          state_next = BK_IDLE;
        end
      end
      BK_REMOVE: begin
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    op_pop        = 1'b0;
    cur_next      = cur;
    head_next     = head;
    count_next    = count;
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    scan_idx_next = scan_idx;
    raddr         = head;
    we            = 1'b0;
    waddr         = wr_ptr;
    wdata         = cur.value;
    rsp_load      = 1'b0;
    res_count     = count;
    rsp_next      = '{out_value: '0, status: ST_OK, is_empty: 1'b0, is_full: 1'b0,
                      entry_count: '0};
    case (state)
      BK_IDLE: begin
        if (start) begin
          op_pop        = 1'b1;
          cur_next      = head_op;
          rd_ptr_next   = head;
          wr_ptr_next   = wrap_dec(head);
          scan_idx_next = '0;
          if (head_op.kind == OP_REFUSE_FULL) begin
            rsp_load        = 1'b1;
            rsp_next.status = ST_FULL;
          end else if (head_op.kind == OP_REFUSE_EMPTY) begin
            rsp_load        = 1'b1;
            rsp_next.status = ST_EMPTY;
          end
        end
      end
      BK_SCAN: begin
        raddr = wrap_inc(rd_ptr);
        we    = 1'b1;
        if (shift_more) begin
          wdata         = rdata;
          wr_ptr_next   = rd_ptr;
          rd_ptr_next   = wrap_inc(rd_ptr);
          scan_idx_next = scan_idx + CNT_W'(1);
        end else begin
          head_next  = wrap_dec(head);
          count_next = count + CNT_W'(1);
          res_count  = count_next;
          rsp_load   = 1'b1;
        end
      end
      BK_REMOVE: begin
        head_next          = wrap_inc(head);
        count_next         = count - CNT_W'(1);
        res_count          = count_next;
        rsp_load           = 1'b1;
        rsp_next.out_value = $signed(rdata);
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
    rsp_next.is_empty    = res_count == '0;
    rsp_next.is_full     = res_count == CNT_W'(QUEUE_DEPTH);
    rsp_next.entry_count = ENTRY_COUNT_W'(res_count);
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    rd_ptr   <= rd_ptr_next;
    wr_ptr   <= wr_ptr_next;
    scan_idx <= scan_idx_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// Flow: the back end loads a refused operation's result word as soon as it takes the operation,
// a remove's word from its BK_REMOVE state, and an insert's word once its scan has passed every
// larger entry.
// The back end runs one operation at a time and takes the next only once the result
// word has left.
// Reset (rst, synchronous) empties the queue and both handshakes; the store is not cleared.
`default_nettype none
module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire spq_pkg::in_word_t  cmd,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output spq_pkg::out_word_t      rsp
);
  import spq_pkg::*;

  // The front end accepts a command word, decides from its own view of the
  // occupancy whether the operation is refused, and queues a classified
  // operation. Because refusals depend only on earlier actions, the front end
  // can decide them without waiting for the store.
  op_t  push_op;
  logic op_push;
  logic op_room;

  // The back end pulls operations out of the short queue and runs them
  // against the circular store, one at a time.
  op_t  head_op;
  logic op_avail;
  logic op_pop;

  spq_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .op_push   (op_push),
    .op_room   (op_room),
    .op        (push_op)
  );

  // The two entries let the front end keep taking words, until both are filled, while the
  // back end is busy with a long insert scan or a stalled result.
  spq_op_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (op_push),
    .push_op (push_op),
    .room    (op_room),
    .pop     (op_pop),
    .avail   (op_avail),
    .head_op (head_op)
  );

  // The back end owns the store, the head index and the live count. An insert
  // walks from the head, moving every larger entry one slot toward the front,
  // then drops the new value into the freed slot.
  spq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_avail  (op_avail),
    .head_op   (head_op),
    .op_pop    (op_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ===== rtl/spq_checker.sv =====
`default_nettype none
`include "sorted_priority_queue_top_macros.svh"
module spq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               rsp_valid,
  input wire logic               rsp_stall,
  input wire spq_pkg::out_word_t rsp
);
  import spq_pkg::*;

  `SPQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result word changed")
  `SPQ_ASSERT_NOW(a_refused_zero, clk, rst, rsp_valid && rsp.status != ST_OK, rsp.out_value == '0, "refused operation returned a value")
  `SPQ_ASSERT_NOW(a_full_flag, clk, rst, rsp_valid && rsp.status == ST_FULL, rsp.is_full, "insert refused while not full")
  `SPQ_ASSERT_NOW(a_empty_flag, clk, rst, rsp_valid && rsp.status == ST_EMPTY, rsp.is_empty && rsp.entry_count == '0, "remove refused while not empty")

endmodule

bind sorted_priority_queue_top spq_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
